// ----- hdl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and codes for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned COUNT_W = 6;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_LOOKUP
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SEND
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef struct packed {
    cell_op_t         op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } cell_cmd_t;

  localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, id: '0, pri: '0};

endpackage

// ----- hdl/spq_req_if.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue request channel
// Valid/ready channel that carries one queue request.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] proc_id;
  logic [7:0]  priority_req;

  modport source (output valid, output mode, output proc_id, output priority_req,
                  input ready);
  modport sink (input valid, input mode, input proc_id, input priority_req,
                output ready);
endinterface

// ----- hdl/spq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue response channel
// Valid/ready channel that carries the result of one request.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_id;
  logic [7:0]  out_priority;
  logic        found;
  logic [5:0]  entry_count;
  logic [1:0]  status;

  modport source (output valid, output out_id, output out_priority, output found,
                  output entry_count, output status, input ready);
  modport sink (input valid, input out_id, input out_priority, input found,
                input entry_count, input status, output ready);
endinterface

// ----- hdl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one queue entry; shifts toward the rear on insert, toward the front
// on pop, and flags an id match on look-up.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::entry_t   left,
  input  logic              left_take,
  input  spq_pkg::entry_t   right,
  output logic              take,
  output spq_pkg::entry_t   entry,
  output logic              match
);

  spq_pkg::entry_t entry_next;

  // A cell takes part in an insert when it is empty or holds a later priority.
  assign take = !entry.valid || (cmd.pri < entry.pri);

  always_comb begin
    entry_next = entry;
    unique case (cmd.op)
      spq_pkg::OP_INSERT: begin
        if (take) begin
          if (left_take) begin
            entry_next = left;
          end else begin
            entry_next = '{valid: 1'b1, id: cmd.id, pri: cmd.pri};
          end
        end
      end
      spq_pkg::OP_POP: entry_next = right;
      spq_pkg::OP_LOOKUP,
      spq_pkg::OP_HOLD: entry_next = entry;
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.id  <= entry_next.id;
    entry.pri <= entry_next.pri;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (cmd.op == spq_pkg::OP_LOOKUP) begin
      match <= entry.valid && (entry.id == cmd.id);
    end
  end

endmodule

// ----- hdl/sorted_priority_ready_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted priority ready queue
// Holds process entries in ascending priority order in a row of cells.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (mode, proc_id, priority_req) and each one
// produces exactly one response on rsp. An insert places the entry behind all
// entries of equal or smaller priority, a pop returns and removes the front
// entry, and a look-up reports whether proc_id is stored. Every response
// carries the entry count after the request, in its low six bits.
// Each cell compares its own entry with the request, so an insert or pop
// updates the whole row in the cycle the request is accepted. The next cycle
// reduces the per-cell look-up matches into the response register, and the
// response is offered in the cycle after that.
// One request is in flight at a time: req is not ready again until the response
// to the last request has been taken. While the receiver stalls, the response
// is held and req stays not ready. Reset empties the queue, leaves no response
// pending and keeps req not ready while it is held.
// ----------------------------------------------------------------------------
module sorted_priority_ready_queue #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic clk,
  input  logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::state_t    state;
  spq_pkg::state_t    state_next;
  spq_pkg::cell_cmd_t cmd;
  spq_pkg::entry_t    entries   [CAPACITY];
  logic               takes     [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic [CAPACITY-1:0] valids;

  logic [CNT_W-1:0]   occupancy;
  logic [CNT_W-1:0]   occupancy_next;
  logic               accept;
  logic               full;
  logic               empty;

  logic                      lookup_q;
  logic [spq_pkg::ID_W-1:0]  res_id;
  logic [spq_pkg::PRI_W-1:0] res_pri;
  logic                      res_found;
  spq_pkg::status_t          res_status;
  spq_pkg::status_t          status_next;

  assign accept = req.valid && req.ready;
  assign full   = (occupancy == CNT_W'(CAPACITY));
  assign empty  = (occupancy == '0);

  always_comb begin
    cmd.op      = spq_pkg::OP_HOLD;
    cmd.id      = req.proc_id;
    cmd.pri     = req.priority_req;
    status_next = spq_pkg::STATUS_OK;
    occupancy_next = occupancy;
    if (accept) begin
      unique case (req.mode)
        spq_pkg::MODE_INSERT: begin
          if (full) begin
            status_next = spq_pkg::STATUS_FULL;
          end else begin
            cmd.op = spq_pkg::OP_INSERT;
            occupancy_next = occupancy + CNT_W'(1);
          end
        end
        spq_pkg::MODE_POP: begin
          if (empty) begin
            status_next = spq_pkg::STATUS_UNDERFLOW;
          end else begin
            cmd.op = spq_pkg::OP_POP;
            occupancy_next = occupancy - CNT_W'(1);
          end
        end
        spq_pkg::MODE_LOOKUP: cmd.op = spq_pkg::OP_LOOKUP;
        default: cmd.op = spq_pkg::OP_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left;
    spq_pkg::entry_t right;
    logic            left_take;

    if (i == 0) begin : g_front
      assign left      = spq_pkg::EMPTY_ENTRY;
      assign left_take = 1'b0;
    end else begin : g_inner
      assign left      = entries[i-1];
      assign left_take = takes[i-1];
    end

    if (i == CAPACITY - 1) begin : g_rear
      assign right = spq_pkg::EMPTY_ENTRY;
    end else begin : g_mid
      assign right = entries[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left      (left),
      .left_take (left_take),
      .right     (right),
      .take      (takes[i]),
      .entry     (entries[i]),
      .match     (hits[i])
    );

    assign valids[i] = entries[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::S_IDLE: if (accept) state_next = spq_pkg::S_EVAL;
      spq_pkg::S_EVAL: state_next = spq_pkg::S_SEND;
      spq_pkg::S_SEND: if (rsp.ready) state_next = spq_pkg::S_IDLE;
      default: state_next = spq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    req.ready = (state == spq_pkg::S_IDLE) && !rst;
    rsp.valid = (state == spq_pkg::S_SEND);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lookup_q   <= (req.mode == spq_pkg::MODE_LOOKUP);
      res_status <= status_next;
      res_found  <= 1'b0;
      if (cmd.op == spq_pkg::OP_POP) begin
        res_id  <= entries[0].id;
        res_pri <= entries[0].pri;
      end else begin
        res_id  <= '0;
        res_pri <= '0;
      end
    end else if (state == spq_pkg::S_EVAL) begin
      res_found <= lookup_q && (|hits);
    end
  end

  assign rsp.out_id       = res_id;
  assign rsp.out_priority = res_pri;
  assign rsp.found        = res_found;
  assign rsp.entry_count  = spq_pkg::COUNT_W'(occupancy);
  assign rsp.status       = res_status;

`ifndef NO_ASSERTIONS
  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(CAPACITY))
    else $error("occupancy exceeds capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valids) == int'(occupancy))
    else $error("cell valid bits disagree with occupancy");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valids} + {{CAPACITY{1'b0}}, 1'b1}))
    else $error("valid cells are not packed at the front");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == spq_pkg::STATUS_UNDERFLOW) |-> occupancy == '0)
    else $error("underflow reported with entries stored");

  a_single_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("second request taken while one is in flight");
`endif

endmodule

// ----- tb/tb_sorted_priority_ready_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted priority ready queue testbench
// Sends insert, pop, look-up and unused-mode requests with random gaps and
// receiver stalls. Every response is checked field by field, against a
// behavioral copy of the queue or, for typed rows, against the table. A directed
// table comes first, then random fill, drain and mixed phases with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_priority_ready_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY    = 32;
  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [spq_pkg::ID_W-1:0]  id;
    logic [spq_pkg::PRI_W-1:0] pri;
  } proc_entry_t;

  typedef struct packed {
    logic [spq_pkg::ID_W-1:0]    out_id;
    logic [spq_pkg::PRI_W-1:0]   out_priority;
    logic                        found;
    logic [spq_pkg::COUNT_W-1:0] entry_count;
    spq_pkg::status_t            status;
  } result_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic [spq_pkg::ID_W-1:0]  id;
    logic [spq_pkg::PRI_W-1:0] pri;
    bit                        typed;
    result_t                   want;
  } stim_row_t;

  localparam result_t PREDICTED = '{16'h0000, 8'h00, 1'b0, 6'd0, spq_pkg::STATUS_OK};

  stim_row_t directed_rows [20] = '{
    '{spq_pkg::MODE_POP,    16'h0000, 8'h00, 1'b1,
      '{16'h0000, 8'h00, 1'b0, 6'd0, spq_pkg::STATUS_UNDERFLOW}},
    '{spq_pkg::MODE_LOOKUP, 16'h0000, 8'h00, 1'b1,
      '{16'h0000, 8'h00, 1'b0, 6'd0, spq_pkg::STATUS_OK}},
    '{MODE_UNUSED,          16'hFFFF, 8'hFF, 1'b1,
      '{16'h0000, 8'h00, 1'b0, 6'd0, spq_pkg::STATUS_OK}},
    '{spq_pkg::MODE_INSERT, 16'hFFFF, 8'hFF, 1'b1,
      '{16'h0000, 8'h00, 1'b0, 6'd1, spq_pkg::STATUS_OK}},
    '{spq_pkg::MODE_INSERT, 16'h0000, 8'h00, 1'b1,
      '{16'h0000, 8'h00, 1'b0, 6'd2, spq_pkg::STATUS_OK}},
    '{spq_pkg::MODE_INSERT, 16'h1234, 8'h80, 1'b0, PREDICTED},
    '{spq_pkg::MODE_INSERT, 16'h5555, 8'h80, 1'b0, PREDICTED},
    '{spq_pkg::MODE_INSERT, 16'hFFFF, 8'h80, 1'b0, PREDICTED},
    '{spq_pkg::MODE_LOOKUP, 16'hFFFF, 8'h00, 1'b0, PREDICTED},
    '{spq_pkg::MODE_LOOKUP, 16'h0000, 8'hFF, 1'b0, PREDICTED},
    '{spq_pkg::MODE_LOOKUP, 16'h7777, 8'h00, 1'b0, PREDICTED},
    '{spq_pkg::MODE_POP,    16'h0000, 8'h00, 1'b1,
      '{16'h0000, 8'h00, 1'b0, 6'd4, spq_pkg::STATUS_OK}},
    '{spq_pkg::MODE_POP,    16'hFFFF, 8'hFF, 1'b0, PREDICTED},
    '{spq_pkg::MODE_POP,    16'h0000, 8'h00, 1'b0, PREDICTED},
    '{spq_pkg::MODE_POP,    16'h0000, 8'h00, 1'b0, PREDICTED},
    '{spq_pkg::MODE_POP,    16'h0000, 8'h00, 1'b1,
      '{16'hFFFF, 8'hFF, 1'b0, 6'd0, spq_pkg::STATUS_OK}},
    '{spq_pkg::MODE_POP,    16'h0000, 8'h00, 1'b1,
      '{16'h0000, 8'h00, 1'b0, 6'd0, spq_pkg::STATUS_UNDERFLOW}},
    '{spq_pkg::MODE_INSERT, 16'hAAAA, 8'h55, 1'b0, PREDICTED},
    '{MODE_UNUSED,          16'h0000, 8'h00, 1'b1,
      '{16'h0000, 8'h00, 1'b0, 6'd1, spq_pkg::STATUS_OK}},
    '{spq_pkg::MODE_LOOKUP, 16'hAAAA, 8'h00, 1'b0, PREDICTED}
  };

  logic clk;
  logic rst;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  sorted_priority_ready_queue #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  proc_entry_t ready_list[$];
  result_t     pending_results[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          no_gaps;
  bit          hold_request;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic result_t apply_request(input logic [1:0] mode,
                                            input logic [spq_pkg::ID_W-1:0] id,
                                            input logic [spq_pkg::PRI_W-1:0] pri);
    result_t     r;
    proc_entry_t head;
    int          pos;
    r.out_id       = '0;
    r.out_priority = '0;
    r.found        = 1'b0;
    r.status       = spq_pkg::STATUS_OK;
    case (mode)
      spq_pkg::MODE_INSERT: begin
        if (ready_list.size() >= CAPACITY) begin
          r.status = spq_pkg::STATUS_FULL;
        end else begin
          pos = ready_list.size();
          for (int i = 0; i < ready_list.size(); i++) begin
            if (pri < ready_list[i].pri) begin
              pos = i;
              break;
            end
          end
          ready_list.insert(pos, '{id, pri});
        end
      end
      spq_pkg::MODE_POP: begin
        if (ready_list.size() == 0) begin
          r.status = spq_pkg::STATUS_UNDERFLOW;
        end else begin
          head           = ready_list.pop_front();
          r.out_id       = head.id;
          r.out_priority = head.pri;
        end
      end
      spq_pkg::MODE_LOOKUP: begin
        foreach (ready_list[i]) begin
          if (ready_list[i].id == id) r.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = spq_pkg::COUNT_W'(ready_list.size());
    return r;
  endfunction

  task automatic send_request(input logic [1:0] mode,
                              input logic [spq_pkg::ID_W-1:0] id,
                              input logic [spq_pkg::PRI_W-1:0] pri, input bit typed,
                              input result_t want);
    result_t predicted;
    while (!no_gaps && $urandom_range(99) < 31) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.mode         <= mode;
    req_bus.proc_id      <= id;
    req_bus.priority_req <= pri;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = apply_request(mode, id, pri);
    pending_results.push_back(typed ? want : predicted);
  endtask

  initial begin
    rsp_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_bus.ready <= no_gaps || ($urandom_range(99) >= 31);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.out_id       = rsp_bus.out_id;
      got.out_priority = rsp_bus.out_priority;
      got.found        = rsp_bus.found;
      got.entry_count  = rsp_bus.entry_count;
      got.status       = spq_pkg::status_t'(rsp_bus.status);
      if (pending_results.size() == 0) begin
        report_mismatch("response arrived with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.out_id !== want.out_id)
          report_mismatch($sformatf("out_id got %h expected %h", got.out_id, want.out_id));
        if (got.out_priority !== want.out_priority)
          report_mismatch($sformatf("out_priority got %h expected %h",
                                    got.out_priority, want.out_priority));
        if (got.found !== want.found)
          report_mismatch($sformatf("found got %b expected %b", got.found, want.found));
        if (got.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d expected %0d",
                                    got.entry_count, want.entry_count));
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", got.status, want.status));
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned insert_share;
    int unsigned roll;
    int unsigned drain_wait;
    logic [1:0]                mode;
    logic [spq_pkg::ID_W-1:0]  id;
    logic [spq_pkg::PRI_W-1:0] pri;

    rst                  <= 1'b1;
    req_bus.valid        <= 1'b0;
    req_bus.mode         <= spq_pkg::MODE_INSERT;
    req_bus.proc_id      <= '0;
    req_bus.priority_req <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].mode, directed_rows[i].id, directed_rows[i].pri,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    sent = $size(directed_rows);

    // The receiver stalls at first; the run of inserts fills the queue, so later inserts report full.
    hold_request = 1'b1;
    repeat (40) begin
      send_request(spq_pkg::MODE_INSERT, spq_pkg::ID_W'($urandom_range(16'hFFFF)),
                   spq_pkg::PRI_W'($urandom_range(255)), 1'b0, PREDICTED);
      sent++;
    end

    phase = 0;
    while (sent < ITEM_TARGET) begin
      no_gaps   = (phase == 6);
      phase_len = no_gaps ? 150 : $urandom_range(120, 40);
      case ($urandom_range(2))
        0:       insert_share = 60;
        1:       insert_share = 15;
        default: insert_share = 40;
      endcase
      repeat (phase_len) begin
        roll = $urandom_range(99);
        if (roll < 2) mode = MODE_UNUSED;
        else if (roll < 20) mode = spq_pkg::MODE_LOOKUP;
        else if (roll < 20 + insert_share) mode = spq_pkg::MODE_INSERT;
        else mode = spq_pkg::MODE_POP;
        id = spq_pkg::ID_W'($urandom_range(16'hFFFF));
        if (mode == spq_pkg::MODE_LOOKUP && ready_list.size() != 0 && $urandom_range(1))
          id = ready_list[$urandom_range(ready_list.size() - 1)].id;
        pri = $urandom_range(1) ? spq_pkg::PRI_W'($urandom_range(255))
                                : spq_pkg::PRI_W'($urandom_range(3) * 85);
        send_request(mode, id, pri, 1'b0, PREDICTED);
        sent++;
      end
      phase++;
    end
    no_gaps = 1'b0;
    req_bus.valid <= 1'b0;

    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/spq_pkg.sv
hdl/spq_req_if.sv
hdl/spq_rsp_if.sv
hdl/spq_cell.sv
hdl/sorted_priority_ready_queue.sv
tb/tb_sorted_priority_ready_queue.sv
